// File: src/tea_pkg.sv
// Shared types, constants and round functions for the TEA encryption pipeline.
package tea_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int DEFAULT_ROUNDS = 32;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

    localparam logic [CFG_INDEX_W-1:0] KEY_WORD0_IDX = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD1_IDX = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD2_IDX = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD3_IDX = 8'd3;

    typedef logic [WORD_W-1:0] tea_word_t;

    typedef struct packed {
        tea_word_t first;
        tea_word_t second;
    } tea_pair_t;

    typedef struct packed {
        tea_word_t word0;
        tea_word_t word1;
        tea_word_t word2;
        tea_word_t word3;
    } tea_key_t;

    // Running sum after round r (counting from zero); only used at elaboration.
    function automatic tea_word_t tea_round_sum(input int unsigned r);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(r + 1);
        return prod[WORD_W-1:0];
    endfunction

    function automatic tea_word_t tea_mix(input tea_word_t w, input tea_word_t sum,
                                          input tea_word_t ka, input tea_word_t kb);
        return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
    endfunction

endpackage

// File: src/tea_if.sv
// Handshake channel interfaces for plaintext, ciphertext and key configuration.
interface tea_plain_if;
    import tea_pkg::*;
    logic      valid;
    logic      ready;
    tea_word_t plain_first;
    tea_word_t plain_second;

    modport source (output valid, output plain_first, output plain_second, input ready);
    modport sink (input valid, input plain_first, input plain_second, output ready);
endinterface

interface tea_cipher_if;
    import tea_pkg::*;
    logic      valid;
    logic      ready;
    tea_word_t cipher_first;
    tea_word_t cipher_second;

    modport source (output valid, output cipher_first, output cipher_second, input ready);
    modport sink (input valid, input cipher_first, input cipher_second, output ready);
endinterface

interface tea_cfg_if;
    import tea_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    tea_word_t              data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/tea_block_encrypt.sv
// TEA block encryption: a row of half-round cells with flow control, plus the key registers.
// Each block passes through 2*ROUNDS half-round cells, one register per cell, before its
// result appears, and one block is accepted every cycle while the output takes results.
// Every cell stalls on its own, so a result waiting at the output still lets requests enter
// until the whole row is full. The key is four 32-bit registers written through the
// configuration channel, indexes 0 to 3; other indexes are ignored. The key feeds all
// cells directly, so write it only while no block is in flight.
module tea_block_encrypt
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = DEFAULT_ROUNDS
)
(
    input  logic         clk,
    input  logic         rst_n,
    tea_cfg_if.sink      cfg,
    tea_plain_if.sink    plain,
    tea_cipher_if.source cipher
);

    localparam int unsigned STAGES = 2 * ROUNDS;
    localparam int unsigned COUNT_W = $clog2(STAGES + 1);

    tea_key_t  key_reg;
    tea_pair_t stage_data [STAGES+1];
    logic      stage_valid [STAGES+1];
    logic      stage_ready [STAGES+1];
    logic [STAGES-1:0] cell_valid;
    logic [COUNT_W-1:0] inflight_reg;
    logic [COUNT_W-1:0] inflight_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                KEY_WORD0_IDX: key_reg.word0 <= cfg.data;
                KEY_WORD1_IDX: key_reg.word1 <= cfg.data;
                KEY_WORD2_IDX: key_reg.word2 <= cfg.data;
                KEY_WORD3_IDX: key_reg.word3 <= cfg.data;
                default: ;
            endcase
        end
    end

    assign stage_valid[0]        = plain.valid;
    assign stage_data[0].first   = plain.plain_first;
    assign stage_data[0].second  = plain.plain_second;
    assign plain.ready           = stage_ready[0];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        tea_cell #(
            .ROUND       (i / 2),
            .SECOND_HALF (1'((i % 2) == 1))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key_reg),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_data  (stage_data[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_data  (stage_data[i+1])
        );
        assign cell_valid[i] = stage_valid[i+1];
    end

    assign cipher.valid         = stage_valid[STAGES];
    assign cipher.cipher_first  = stage_data[STAGES].first;
    assign cipher.cipher_second = stage_data[STAGES].second;
    assign stage_ready[STAGES]  = cipher.ready;

    // Count of blocks inside the row, kept for checking the flow control.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (plain.valid && plain.ready)
        begin
            inflight_next = inflight_next + COUNT_W'(1);
        end
        if (cipher.valid && cipher.ready)
        begin
            inflight_next = inflight_next - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(inflight_reg))
        else $error("occupied cells differ from the number of blocks in flight");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !plain.ready |-> (&cell_valid && !cipher.ready))
        else $error("input refused while the row still has room");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(inflight_reg) <= STAGES)
        else $error("more blocks in flight than cells");

endmodule

// File: src/tea_cell.sv
// One half-round cell of the TEA pipeline with its own stage register.
module tea_cell
    import tea_pkg::*;
#(
    parameter int unsigned ROUND = 0,
    parameter bit SECOND_HALF = 1'b0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  tea_key_t  key,
    input  logic      up_valid,
    output logic      up_ready,
    input  tea_pair_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output tea_pair_t dn_data
);

    localparam tea_word_t SUM = tea_round_sum(ROUND);

    logic      valid_reg;
    tea_pair_t data_reg;
    tea_pair_t data_next;

    // The cell can take a request when it is empty or its content moves on.
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next = up_data;
        if (SECOND_HALF)
        begin
            data_next.second = up_data.second
                             + tea_mix(up_data.first, SUM, key.word2, key.word3);
        end
        else
        begin
            data_next.first = up_data.first
                            + tea_mix(up_data.second, SUM, key.word0, key.word1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
